FILE: hw/rtl/imh_pkg.sv
// Shared types, codes and constants of the indexed min-heap.
package imh_pkg;

	localparam int unsigned CAPACITY_DEF = 1024;
	localparam int unsigned ACTION_W = 3;
	localparam int unsigned HANDLE_W = 11;
	localparam int unsigned KEY_W = 32;

	localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_EXTRACT = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_CHANGE = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd4;

	localparam logic STATUS_OK = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [HANDLE_W-1:0] handle;
		logic signed [KEY_W-1:0] key_value;
	} req_t;

	typedef struct packed {
		logic status;
		logic signed [KEY_W-1:0] extracted_value;
		logic [HANDLE_W-1:0] assigned_handle;
		logic [HANDLE_W-1:0] heap_size;
		logic signed [KEY_W-1:0] min_value;
		logic heap_empty;
	} rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_DISPATCH, ST_EX_H, ST_EX_V, ST_CHK_POS, ST_CHK_H,
		ST_REM, ST_REM_H, ST_REM_V, ST_UP_RD, ST_UP_H, ST_UP_CMP,
		ST_DN_RD, ST_DN_H, ST_DN_CMP, ST_PLACE, ST_FIN, ST_MIN_H,
		ST_MIN_V, ST_OUT
	} state_t;

	typedef enum logic [4:0] {
		CMD_NONE, CMD_LOAD, CMD_INS, CMD_CLR, CMD_RD_ROOT, CMD_RD_HV,
		CMD_EX_LATCH, CMD_RD_POS, CMD_CHK_POS, CMD_CHG, CMD_REM, CMD_REM_V,
		CMD_UP_RD, CMD_UP_MOVE, CMD_DN_RD, CMD_DN_RDV, CMD_DN_MOVE,
		CMD_PLACE, CMD_MIN_ZERO, CMD_MIN_LATCH, CMD_OUT
	} cmd_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic ins_ok;
		logic cnt_zero;
		logic hrange_ok;
		logic pos_ok;
		logic h_match;
		logic is_last;
		logic s_zero;
		logic up_go;
		logic dn_has_l;
		logic dn_go;
		logic rsp_busy;
	} dp_status_t;

endpackage

FILE: hw/rtl/imh_ctrl.sv
// Sequencer of the indexed min-heap: issues one datapath command per cycle.
module imh_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input imh_pkg::dp_status_t st,
	output imh_pkg::cmd_t cmd
);

	imh_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= imh_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = imh_pkg::CMD_NONE;
		req_ready = 1'b0;
		case (state_q)
			imh_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd = imh_pkg::CMD_LOAD;
					state_d = imh_pkg::ST_DISPATCH;
				end
			end
			imh_pkg::ST_DISPATCH: begin
				state_d = imh_pkg::ST_FIN;
				case (st.action)
					imh_pkg::ACT_INSERT: begin
						if (st.ins_ok) begin
							cmd = imh_pkg::CMD_INS;
							state_d = imh_pkg::ST_UP_RD;
						end
					end
					imh_pkg::ACT_EXTRACT: begin
						if (!st.cnt_zero) begin
							cmd = imh_pkg::CMD_RD_ROOT;
							state_d = imh_pkg::ST_EX_H;
						end
					end
					imh_pkg::ACT_DELETE, imh_pkg::ACT_CHANGE: begin
						if (st.hrange_ok) begin
							cmd = imh_pkg::CMD_RD_POS;
							state_d = imh_pkg::ST_CHK_POS;
						end
					end
					imh_pkg::ACT_CLEAR: begin
						cmd = imh_pkg::CMD_CLR;
					end
					default: begin
						cmd = imh_pkg::CMD_NONE;
					end
				endcase
			end
			imh_pkg::ST_EX_H: begin
				cmd = imh_pkg::CMD_RD_HV;
				state_d = imh_pkg::ST_EX_V;
			end
			imh_pkg::ST_EX_V: begin
				cmd = imh_pkg::CMD_EX_LATCH;
				state_d = imh_pkg::ST_REM;
			end
			imh_pkg::ST_CHK_POS: begin
				if (st.pos_ok) begin
					cmd = imh_pkg::CMD_CHK_POS;
					state_d = imh_pkg::ST_CHK_H;
				end else begin
					state_d = imh_pkg::ST_FIN;
				end
			end
			imh_pkg::ST_CHK_H: begin
				if (!st.h_match) begin
					state_d = imh_pkg::ST_FIN;
				end else if (st.action == imh_pkg::ACT_DELETE) begin
					state_d = imh_pkg::ST_REM;
				end else begin
					cmd = imh_pkg::CMD_CHG;
					state_d = imh_pkg::ST_UP_RD;
				end
			end
			imh_pkg::ST_REM: begin
				cmd = imh_pkg::CMD_REM;
				state_d = st.is_last ? imh_pkg::ST_FIN : imh_pkg::ST_REM_H;
			end
			imh_pkg::ST_REM_H: begin
				cmd = imh_pkg::CMD_RD_HV;
				state_d = imh_pkg::ST_REM_V;
			end
			imh_pkg::ST_REM_V: begin
				cmd = imh_pkg::CMD_REM_V;
				state_d = imh_pkg::ST_UP_RD;
			end
			imh_pkg::ST_UP_RD: begin
				if (st.s_zero) begin
					state_d = imh_pkg::ST_DN_RD;
				end else begin
					cmd = imh_pkg::CMD_UP_RD;
					state_d = imh_pkg::ST_UP_H;
				end
			end
			imh_pkg::ST_UP_H: begin
				cmd = imh_pkg::CMD_RD_HV;
				state_d = imh_pkg::ST_UP_CMP;
			end
			imh_pkg::ST_UP_CMP: begin
				if (st.up_go) begin
					cmd = imh_pkg::CMD_UP_MOVE;
					state_d = imh_pkg::ST_UP_RD;
				end else begin
					state_d = imh_pkg::ST_DN_RD;
				end
			end
			imh_pkg::ST_DN_RD: begin
				if (st.dn_has_l) begin
					cmd = imh_pkg::CMD_DN_RD;
					state_d = imh_pkg::ST_DN_H;
				end else begin
					state_d = imh_pkg::ST_PLACE;
				end
			end
			imh_pkg::ST_DN_H: begin
				cmd = imh_pkg::CMD_DN_RDV;
				state_d = imh_pkg::ST_DN_CMP;
			end
			imh_pkg::ST_DN_CMP: begin
				if (st.dn_go) begin
					cmd = imh_pkg::CMD_DN_MOVE;
					state_d = imh_pkg::ST_DN_RD;
				end else begin
					state_d = imh_pkg::ST_PLACE;
				end
			end
			imh_pkg::ST_PLACE: begin
				cmd = imh_pkg::CMD_PLACE;
				state_d = imh_pkg::ST_FIN;
			end
			imh_pkg::ST_FIN: begin
				if (st.cnt_zero) begin
					cmd = imh_pkg::CMD_MIN_ZERO;
					state_d = imh_pkg::ST_OUT;
				end else begin
					cmd = imh_pkg::CMD_RD_ROOT;
					state_d = imh_pkg::ST_MIN_H;
				end
			end
			imh_pkg::ST_MIN_H: begin
				cmd = imh_pkg::CMD_RD_HV;
				state_d = imh_pkg::ST_MIN_V;
			end
			imh_pkg::ST_MIN_V: begin
				cmd = imh_pkg::CMD_MIN_LATCH;
				state_d = imh_pkg::ST_OUT;
			end
			imh_pkg::ST_OUT: begin
				if (!st.rsp_busy) begin
					cmd = imh_pkg::CMD_OUT;
					state_d = imh_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = imh_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/imh_dpath.sv
// Datapath of the indexed min-heap: heap memories, sift registers and result register.
module imh_dpath #(
	parameter int unsigned CAPACITY = imh_pkg::CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input imh_pkg::cmd_t cmd,
	output imh_pkg::dp_status_t st,
	input imh_pkg::req_t req_data,
	output logic rsp_valid,
	input logic rsp_ready,
	output imh_pkg::rsp_t rsp_data
);

	localparam int unsigned IW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned DW = IW + 2;
	localparam int unsigned WW = ((CW > imh_pkg::HANDLE_W) ? CW : imh_pkg::HANDLE_W) + 1;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [IW-1:0] sh_mem [CAPACITY];
	logic [IW-1:0] hp_mem [CAPACITY];
	logic signed [imh_pkg::KEY_W-1:0] hv_mem [CAPACITY];

	logic [CW-1:0] cnt_q, nh_q;
	logic rsp_valid_q;
	imh_pkg::rsp_t rsp_q;

	logic [imh_pkg::ACTION_W-1:0] act_q;
	logic [imh_pkg::HANDLE_W-1:0] hin_q;
	logic signed [imh_pkg::KEY_W-1:0] kv_q;
	logic status_q;
	logic signed [imh_pkg::KEY_W-1:0] ext_q, min_q, cur_v_q;
	logic [imh_pkg::HANDLE_W-1:0] asg_q;
	logic [IW-1:0] s_q, pos_q, cur_h_q;
	logic [IW-1:0] sha_q, shb_q, hp_q;
	logic signed [imh_pkg::KEY_W-1:0] hva_q, hvb_q;

	logic sh_rea, sh_reb, hv_rea, hv_reb, hp_re;
	logic [IW-1:0] sh_ra, sh_rb, hv_ra, hv_rb, hp_ra;
	logic sh_we, hp_we, hv_we;
	logic [IW-1:0] sh_wa, sh_wd, hp_wa, hp_wd, hv_wa;
	logic signed [imh_pkg::KEY_W-1:0] hv_wd;

	logic [IW-1:0] h_idx, s_m1, parent, best_slot, best_h;
	logic [DW-1:0] l_w, r_w, cnt_w;
	logic r_ok, l_less, r_less;
	logic signed [imh_pkg::KEY_W-1:0] l_best_v;

	assign h_idx = IW'(hin_q - imh_pkg::HANDLE_W'(1));
	assign s_m1 = s_q - IW'(1);
	assign parent = s_m1 >> 1;
	assign l_w = DW'({s_q, 1'b1});
	assign r_w = l_w + DW'(1);
	assign cnt_w = DW'(cnt_q);
	assign r_ok = r_w < cnt_w;
	assign l_less = hva_q < cur_v_q;
	assign l_best_v = l_less ? hva_q : cur_v_q;
	assign r_less = r_ok && (hvb_q < l_best_v);
	assign best_slot = r_less ? IW'(r_w) : IW'(l_w);
	assign best_h = r_less ? shb_q : sha_q;

	always_comb begin
		st.action = act_q;
		st.ins_ok = (nh_q < CAP_C) && (cnt_q < CAP_C);
		st.cnt_zero = cnt_q == '0;
		st.hrange_ok = (hin_q != '0) && (WW'(hin_q) <= WW'(nh_q)) &&
			(WW'(hin_q) <= WW'(CAPACITY));
		st.pos_ok = DW'(hp_q) < cnt_w;
		st.h_match = sha_q == h_idx;
		st.is_last = DW'(pos_q) == (cnt_w - DW'(1));
		st.s_zero = s_q == '0;
		st.up_go = cur_v_q < hva_q;
		st.dn_has_l = l_w < cnt_w;
		st.dn_go = l_less || r_less;
		st.rsp_busy = rsp_valid_q && !rsp_ready;
	end

	always_comb begin
		sh_rea = 1'b0;
		sh_reb = 1'b0;
		hv_rea = 1'b0;
		hv_reb = 1'b0;
		hp_re = 1'b0;
		sh_ra = '0;
		sh_rb = '0;
		hv_ra = sha_q;
		hv_rb = shb_q;
		hp_ra = h_idx;
		sh_we = 1'b0;
		hp_we = 1'b0;
		hv_we = 1'b0;
		sh_wa = s_q;
		sh_wd = cur_h_q;
		hp_wa = cur_h_q;
		hp_wd = s_q;
		hv_wa = h_idx;
		hv_wd = kv_q;
		case (cmd)
			imh_pkg::CMD_INS: begin
				hv_we = 1'b1;
				hv_wa = IW'(nh_q);
			end
			imh_pkg::CMD_RD_ROOT: begin
				sh_rea = 1'b1;
			end
			imh_pkg::CMD_RD_HV: begin
				hv_rea = 1'b1;
			end
			imh_pkg::CMD_RD_POS: begin
				hp_re = 1'b1;
			end
			imh_pkg::CMD_CHK_POS: begin
				sh_rea = 1'b1;
				sh_ra = hp_q;
			end
			imh_pkg::CMD_CHG: begin
				hv_we = 1'b1;
			end
			imh_pkg::CMD_REM: begin
				sh_rea = 1'b1;
				sh_ra = IW'(cnt_q - CW'(1));
			end
			imh_pkg::CMD_UP_RD: begin
				sh_rea = 1'b1;
				sh_ra = parent;
			end
			imh_pkg::CMD_UP_MOVE: begin
				sh_we = 1'b1;
				sh_wd = sha_q;
				hp_we = 1'b1;
				hp_wa = sha_q;
			end
			imh_pkg::CMD_DN_RD: begin
				sh_rea = 1'b1;
				sh_reb = 1'b1;
				sh_ra = IW'(l_w);
				sh_rb = r_ok ? IW'(r_w) : '0;
			end
			imh_pkg::CMD_DN_RDV: begin
				hv_rea = 1'b1;
				hv_reb = 1'b1;
			end
			imh_pkg::CMD_DN_MOVE: begin
				sh_we = 1'b1;
				sh_wd = best_h;
				hp_we = 1'b1;
				hp_wa = best_h;
			end
			imh_pkg::CMD_PLACE: begin
				sh_we = 1'b1;
				hp_we = 1'b1;
			end
			default: begin
				sh_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sh_we) begin
			sh_mem[sh_wa] <= sh_wd;
		end
		if (sh_rea) begin
			sha_q <= sh_mem[sh_ra];
		end
		if (sh_reb) begin
			shb_q <= sh_mem[sh_rb];
		end
	end

	always_ff @(posedge clk) begin
		if (hp_we) begin
			hp_mem[hp_wa] <= hp_wd;
		end
		if (hp_re) begin
			hp_q <= hp_mem[hp_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (hv_we) begin
			hv_mem[hv_wa] <= hv_wd;
		end
		if (hv_rea) begin
			hva_q <= hv_mem[hv_ra];
		end
		if (hv_reb) begin
			hvb_q <= hv_mem[hv_rb];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			nh_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (cmd)
				imh_pkg::CMD_INS: begin
					cnt_q <= cnt_q + CW'(1);
					nh_q <= nh_q + CW'(1);
				end
				imh_pkg::CMD_CLR: begin
					cnt_q <= '0;
				end
				imh_pkg::CMD_REM: begin
					cnt_q <= cnt_q - CW'(1);
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
			if (cmd == imh_pkg::CMD_OUT) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd)
			imh_pkg::CMD_LOAD: begin
				act_q <= req_data.action;
				hin_q <= req_data.handle;
				kv_q <= req_data.key_value;
				status_q <= imh_pkg::STATUS_ERR;
				ext_q <= '0;
				asg_q <= '0;
			end
			imh_pkg::CMD_INS: begin
				cur_h_q <= IW'(nh_q);
				cur_v_q <= kv_q;
				s_q <= IW'(cnt_q);
				asg_q <= imh_pkg::HANDLE_W'(nh_q + CW'(1));
				status_q <= imh_pkg::STATUS_OK;
			end
			imh_pkg::CMD_CLR: begin
				status_q <= imh_pkg::STATUS_OK;
			end
			imh_pkg::CMD_EX_LATCH: begin
				ext_q <= hva_q;
				pos_q <= '0;
			end
			imh_pkg::CMD_CHK_POS: begin
				pos_q <= hp_q;
			end
			imh_pkg::CMD_CHG: begin
				cur_h_q <= h_idx;
				cur_v_q <= kv_q;
				s_q <= pos_q;
				status_q <= imh_pkg::STATUS_OK;
			end
			imh_pkg::CMD_REM: begin
				status_q <= imh_pkg::STATUS_OK;
			end
			imh_pkg::CMD_REM_V: begin
				cur_h_q <= sha_q;
				cur_v_q <= hva_q;
				s_q <= pos_q;
			end
			imh_pkg::CMD_UP_MOVE: begin
				s_q <= parent;
			end
			imh_pkg::CMD_DN_MOVE: begin
				s_q <= best_slot;
			end
			imh_pkg::CMD_MIN_ZERO: begin
				min_q <= '0;
			end
			imh_pkg::CMD_MIN_LATCH: begin
				min_q <= hva_q;
			end
			imh_pkg::CMD_OUT: begin
				rsp_q.status <= status_q;
				rsp_q.extracted_value <= ext_q;
				rsp_q.assigned_handle <= asg_q;
				rsp_q.heap_size <= imh_pkg::HANDLE_W'(cnt_q);
				rsp_q.min_value <= min_q;
				rsp_q.heap_empty <= cnt_q == '0;
			end
			default: begin
				s_q <= s_q;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_q;

endmodule

FILE: hw/rtl/indexed_min_heap.sv
// Top level of the indexed min-heap priority queue.
// Usage:
//   req channel (req_valid, req_ready, req_data) takes one action per
//   transaction: insert, extract minimum, delete or change by handle, clear.
//   rsp channel (rsp_valid, rsp_ready, rsp_data) returns exactly one result
//   per action, in order: status, extracted value, assigned handle, size,
//   current minimum and empty flag.
// Sequencing: one action at a time. The next request can be taken from the
//   cycle in which the result becomes valid. Each level a sift moves takes a
//   slot-handle read, a value read and a compare-and-move step, for up to
//   log2(CAPACITY) levels; handle lookup, removal setup, placement and
//   minimum readback are added around the sift.
// Reset: clears the entry count and the handle counter; no memory sweep is
//   needed, so the block is ready right after reset.
// Stall: a result waits in the output register; the next request is taken
//   meanwhile and held at its end until the output register is free.
module indexed_min_heap #(
	parameter int unsigned CAPACITY = imh_pkg::CAPACITY_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input imh_pkg::req_t req_data,
	output logic rsp_valid,
	input logic rsp_ready,
	output imh_pkg::rsp_t rsp_data
);

	imh_pkg::cmd_t cmd;
	imh_pkg::dp_status_t st;

	imh_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.st(st),
		.cmd(cmd)
	);

	imh_dpath #(
		.CAPACITY(CAPACITY)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.st(st),
		.req_data(req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data(rsp_data)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while an action is in flight");

	a_empty_min_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.heap_empty |-> rsp_data.min_value == '0)
		else $error("empty heap reports a nonzero minimum");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status == imh_pkg::STATUS_ERR) |->
		(rsp_data.extracted_value == '0) && (rsp_data.assigned_handle == '0))
		else $error("failed action reports a value or handle");

endmodule

FILE: test/tb_indexed_min_heap.sv
// Self-checking testbench for indexed_min_heap: directed and random actions vs. a heap predictor.
`timescale 1ns / 1ps

module tb_indexed_min_heap;

	localparam int CAP = 1024;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOG_START = 1000;
	localparam int HOG_LEN = 400;
	localparam int QUIET_LO = 2500;
	localparam int QUIET_HI = 4500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid;
	logic req_ready;
	imh_pkg::req_t req_data;
	logic rsp_valid;
	logic rsp_ready;
	imh_pkg::rsp_t rsp_data;

	imh_pkg::req_t pending_reqs[$];
	imh_pkg::rsp_t expected_rsps[$];
	int cycle = 0;
	int rx_cycle = 0;
	int errors = 0;
	int issued_est = 0;

	logic [9:0] slot_hnd[CAP];
	int hnd_slot[CAP];
	bit hnd_live[CAP];
	logic signed [31:0] hnd_key[CAP];
	int live_count = 0;
	int handles_used = 0;

	indexed_min_heap dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic signed [31:0] key_at(int slot);
		return hnd_key[slot_hnd[slot]];
	endfunction

	function automatic void swap_slot(int a, int b);
		logic [9:0] ha;
		logic [9:0] hb;
		ha = slot_hnd[a];
		hb = slot_hnd[b];
		slot_hnd[a] = hb;
		slot_hnd[b] = ha;
		hnd_slot[hb] = a;
		hnd_slot[ha] = b;
	endfunction

	function automatic int bubble_up(int slot);
		int parent;
		while (slot != 0) begin
			parent = (slot - 1) / 2;
			if (!(key_at(slot) < key_at(parent)))
				break;
			swap_slot(slot, parent);
			slot = parent;
		end
		return slot;
	endfunction

	function automatic void bubble_down(int slot);
		int l;
		int r;
		int best;
		forever begin
			l = 2 * slot + 1;
			r = l + 1;
			best = slot;
			if (l < live_count && key_at(l) < key_at(best))
				best = l;
			if (r < live_count && key_at(r) < key_at(best))
				best = r;
			if (best == slot)
				break;
			swap_slot(slot, best);
			slot = best;
		end
	endfunction

	function automatic void drop_slot(int slot);
		int gone;
		int last;
		gone = int'(slot_hnd[slot]);
		last = live_count - 1;
		if (slot != last)
			swap_slot(slot, last);
		live_count = last;
		hnd_live[gone] = 1'b0;
		if (slot < live_count)
			bubble_down(bubble_up(slot));
	endfunction

	function automatic imh_pkg::rsp_t heap_apply(imh_pkg::req_t rq);
		imh_pkg::rsp_t rs;
		int h;
		bit h_ok;
		rs = '0;
		rs.status = imh_pkg::STATUS_ERR;
		h = int'(rq.handle);
		h_ok = h >= 1 && h <= handles_used && h <= CAP && hnd_live[(h - 1) % CAP];
		case (rq.action)
			imh_pkg::ACT_INSERT: begin
				if (handles_used < CAP && live_count < CAP) begin
					slot_hnd[live_count] = 10'(handles_used);
					hnd_slot[handles_used] = live_count;
					hnd_live[handles_used] = 1'b1;
					hnd_key[handles_used] = rq.key_value;
					live_count++;
					handles_used++;
					void'(bubble_up(live_count - 1));
					rs.assigned_handle = 11'(handles_used);
					rs.status = imh_pkg::STATUS_OK;
				end
			end
			imh_pkg::ACT_EXTRACT: begin
				if (live_count > 0) begin
					rs.extracted_value = key_at(0);
					drop_slot(0);
					rs.status = imh_pkg::STATUS_OK;
				end
			end
			imh_pkg::ACT_DELETE: begin
				if (h_ok && hnd_slot[h - 1] < live_count) begin
					drop_slot(hnd_slot[h - 1]);
					rs.status = imh_pkg::STATUS_OK;
				end
			end
			imh_pkg::ACT_CHANGE: begin
				if (h_ok && hnd_slot[h - 1] < live_count) begin
					hnd_key[h - 1] = rq.key_value;
					bubble_down(bubble_up(hnd_slot[h - 1]));
					rs.status = imh_pkg::STATUS_OK;
				end
			end
			imh_pkg::ACT_CLEAR: begin
				live_count = 0;
				foreach (hnd_live[i])
					hnd_live[i] = 1'b0;
				rs.status = imh_pkg::STATUS_OK;
			end
			default: ;
		endcase
		rs.heap_size = 11'(live_count);
		rs.min_value = live_count > 0 ? key_at(0) : '0;
		rs.heap_empty = live_count == 0;
		return rs;
	endfunction

	function automatic bit quiet_now();
		return cycle >= QUIET_LO && cycle < QUIET_HI;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
		end else begin
			automatic bit taken = req_valid && req_ready;
			if (taken)
				expected_rsps.push_back(heap_apply(req_data));
			if (!req_valid || taken) begin
				if (pending_reqs.size() > 0 && (quiet_now() || $urandom_range(99) >= 23)) begin
					req_valid <= 1'b1;
					req_data <= pending_reqs.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rx_cycle <= 0;
		end else begin
			automatic imh_pkg::rsp_t exp_rs;
			rx_cycle <= rx_cycle + 1;
			if (rsp_valid && rsp_ready) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected transaction: %p", rsp_data);
					errors++;
				end else begin
					exp_rs = expected_rsps.pop_front();
					if (rsp_data.status !== exp_rs.status) begin
						$error("status exp %0d got %0d", exp_rs.status, rsp_data.status);
						errors++;
					end
					if (rsp_data.extracted_value !== exp_rs.extracted_value) begin
						$error("extracted_value exp %0d got %0d",
							exp_rs.extracted_value, rsp_data.extracted_value);
						errors++;
					end
					if (rsp_data.assigned_handle !== exp_rs.assigned_handle) begin
						$error("assigned_handle exp %0d got %0d",
							exp_rs.assigned_handle, rsp_data.assigned_handle);
						errors++;
					end
					if (rsp_data.heap_size !== exp_rs.heap_size) begin
						$error("heap_size exp %0d got %0d", exp_rs.heap_size, rsp_data.heap_size);
						errors++;
					end
					if (rsp_data.min_value !== exp_rs.min_value) begin
						$error("min_value exp %0d got %0d", exp_rs.min_value, rsp_data.min_value);
						errors++;
					end
					if (rsp_data.heap_empty !== exp_rs.heap_empty) begin
						$error("heap_empty exp %0d got %0d", exp_rs.heap_empty, rsp_data.heap_empty);
						errors++;
					end
				end
			end
			if (rx_cycle >= HOG_START && rx_cycle < HOG_START + HOG_LEN)
				rsp_ready <= 1'b0;
			else
				rsp_ready <= quiet_now() || $urandom_range(99) >= 23;
		end
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic logic signed [31:0] rand_key();
		case ($urandom_range(3))
			0: return $signed($urandom_range(20)) - 10;
			1: return 32'h7fff_ffff - $urandom_range(3);
			2: return 32'h8000_0000 + $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_req(logic [2:0] act, logic [10:0] hnd, logic signed [31:0] k);
		imh_pkg::req_t rq;
		rq.action = act;
		rq.handle = hnd;
		rq.key_value = k;
		if (act == imh_pkg::ACT_INSERT)
			issued_est++;
		pending_reqs.push_back(rq);
	endtask

	task automatic queue_random();
		int pick;
		logic [10:0] hnd;
		pick = $urandom_range(99);
		if ($urandom_range(9) == 0)
			hnd = 11'($urandom);
		else
			hnd = 11'($urandom_range(issued_est + 1, issued_est > 40 ? issued_est - 40 : 0));
		if (pick < 40)
			queue_req(imh_pkg::ACT_INSERT, 11'($urandom), rand_key());
		else if (pick < 60)
			queue_req(imh_pkg::ACT_EXTRACT, 11'($urandom), $urandom);
		else if (pick < 76)
			queue_req(imh_pkg::ACT_DELETE, hnd, $urandom);
		else if (pick < 94)
			queue_req(imh_pkg::ACT_CHANGE, hnd, rand_key());
		else if (pick < 97)
			queue_req(imh_pkg::ACT_CLEAR, hnd, $urandom);
		else
			queue_req(3'($urandom_range(7, 5)), hnd, $urandom);
	endtask

	task automatic drain();
		wait (pending_reqs.size() == 0 && !req_valid && expected_rsps.size() == 0);
		@(posedge clk);
	endtask

	initial begin
		foreach (hnd_live[i])
			hnd_live[i] = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		queue_req(imh_pkg::ACT_EXTRACT, 0, 0);
		queue_req(imh_pkg::ACT_DELETE, 1, 0);
		queue_req(imh_pkg::ACT_INSERT, 0, 32'sh7fff_ffff);
		queue_req(imh_pkg::ACT_INSERT, 11'h7ff, 32'sh8000_0000);
		queue_req(imh_pkg::ACT_INSERT, 0, 0);
		queue_req(imh_pkg::ACT_INSERT, 0, -1);
		queue_req(imh_pkg::ACT_INSERT, 0, 0);
		queue_req(imh_pkg::ACT_CHANGE, 1, 32'sh8000_0000);
		queue_req(imh_pkg::ACT_CHANGE, 2, 32'sh7fff_ffff);
		queue_req(imh_pkg::ACT_DELETE, 0, 0);
		queue_req(imh_pkg::ACT_DELETE, 11'h7ff, 0);
		queue_req(imh_pkg::ACT_DELETE, 6, 0);
		queue_req(imh_pkg::ACT_DELETE, 3, 0);
		queue_req(imh_pkg::ACT_DELETE, 3, 0);
		queue_req(imh_pkg::ACT_CHANGE, 3, 5);
		queue_req(imh_pkg::ACT_EXTRACT, 0, 0);
		queue_req(3'd5, 1, 0);
		queue_req(3'd6, 1, 0);
		queue_req(3'd7, 1, 0);
		queue_req(imh_pkg::ACT_CLEAR, 0, 0);
		queue_req(imh_pkg::ACT_CHANGE, 2, 1);
		queue_req(imh_pkg::ACT_EXTRACT, 0, 0);
		drain();

		for (int b = 0; b < 5; b++) begin
			for (int i = 0; i < 100; i++)
				queue_random();
			drain();
		end

		repeat (100) @(posedge clk);
		if (errors == 0 && expected_rsps.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/imh_pkg.sv
hw/rtl/imh_ctrl.sv
hw/rtl/imh_dpath.sv
hw/rtl/indexed_min_heap.sv
test/tb_indexed_min_heap.sv
